FILE: src/kls_pkg.sv
// ----------------------------------------------------------------------------
// kls_pkg: shared definitions of the keyframe light sequencer
// Sizes, codes, register layout and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package kls_pkg;

  localparam int BEAM_COUNT = 8;
  localparam int MAX_STEPS  = 8;
  localparam int TABLE_SIZE = BEAM_COUNT * MAX_STEPS;

  localparam int BEAM_W  = (BEAM_COUNT > 1) ? $clog2(BEAM_COUNT) : 1;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int ADDR_W  = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int POS_W   = 8;
  localparam int PROD_W  = 2 * POS_W;
  localparam int DCNT_W  = $clog2(PROD_W + 1);

  localparam logic [3:0] RESET_STEP_COUNT  = 4'd5;
  localparam logic [7:0] RESET_INNER_STEPS = 8'd40;

  localparam logic REG_STEP_COUNT  = 1'b0;
  localparam logic REG_INNER_STEPS = 1'b1;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_POWER    = 2'd0,
    KIND_POSITION = 2'd1,
    KIND_FINISHED = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OPEN,
    ST_FINISH,
    ST_POW_RD,
    ST_POW_EMIT,
    ST_POS_RD,
    ST_POS_MUL,
    ST_POS_DIV,
    ST_POS_EMIT
  } state_t;

  typedef struct packed {
    logic [3:0] step_count;
    logic [7:0] inner_steps;
  } cfg_t;

  function automatic logic [ADDR_W-1:0] table_addr(input logic [7:0] b, input logic [7:0] s);
    return ADDR_W'(int'(b) * MAX_STEPS + int'(s));
  endfunction

endpackage

`default_nettype wire

FILE: src/kls_keyframe_ram.sv
// ----------------------------------------------------------------------------
// kls_keyframe_ram: keyframe table storage
// Position and power targets per beam and step, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_keyframe_ram
  import kls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [POS_W-1:0]  wr_position,
  input  wire logic [7:0]        wr_power,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [POS_W-1:0]  rd_position,
  output logic      [7:0]        rd_power
);

  logic [POS_W-1:0] position_mem [TABLE_SIZE];
  logic [7:0]       power_mem    [TABLE_SIZE];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      position_mem[wr_addr] <= wr_position;
      power_mem[wr_addr]    <= wr_power;
    end
  end

  always_ff @(posedge clk) begin
    rd_position <= position_mem[rd_addr];
    rd_power    <= power_mem[rd_addr];
  end

endmodule

`default_nettype wire

FILE: src/kls_divider.sv
// ----------------------------------------------------------------------------
// kls_divider: serial restoring divider
// Divides a 16-bit numerator by an 8-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_divider
  import kls_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] numerator,
  input  wire logic [7:0]        divisor,
  output logic                   busy,
  output logic                   done,
  output logic      [POS_W-1:0]  quotient
);

  logic [PROD_W-1:0] quo;
  logic [7:0]        rem;
  logic [7:0]        dsr;
  logic [DCNT_W-1:0] cnt;
  logic [8:0]        trial;
  logic [8:0]        diff;
  logic              fits;

  always_comb begin
    trial = {rem, quo[PROD_W-1]};
    diff  = trial - {1'b0, dsr};
    fits  = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(PROD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= numerator;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[PROD_W-2:0], fits};
      rem <= fits ? diff[7:0] : trial[7:0];
    end
  end

  assign quotient = quo[POS_W-1:0];

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not go busy after start");
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
`endif

endmodule

`default_nettype wire

FILE: src/kls_apb_regs.sv
// ----------------------------------------------------------------------------
// kls_apb_regs: configuration registers
// Step count and inner step count behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module kls_apb_regs
  import kls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_count  <= RESET_STEP_COUNT;
      cfg.inner_steps <= RESET_INNER_STEPS;
    end else if (wr) begin
      unique case (paddr[2])
        REG_STEP_COUNT:  cfg.step_count  <= pwdata[3:0];
        REG_INNER_STEPS: cfg.inner_steps <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STEP_COUNT:  prdata = {28'd0, cfg.step_count};
      REG_INNER_STEPS: prdata = {24'd0, cfg.inner_steps};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: src/keyframe_light_sequencer.sv
// A tick gives one position word for each of the eight beams in turn; each beam
// passes through a table read, a multiply and the shared divider to its word.
// A start or a step change gives eight power words, or a finished word when no
// step is left, as does a tick past the last step. New words wait meanwhile.
// Table writes, stops and ignored words do not stall. Reset is synchronous;
// the keyframe table is not cleared and holds nothing defined until written.
// ----------------------------------------------------------------------------
// keyframe_light_sequencer: keyframe interpolation sequencer
// Steps through a keyframe table, issuing power commands at each step,
// linearly interpolated position commands at the other ticks and a finished command at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module keyframe_light_sequencer
  import kls_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  operation,
  input  wire logic [2:0]  beam_index,
  input  wire logic [2:0]  step_index,
  input  wire logic [7:0]  target_position,
  input  wire logic [7:0]  target_power,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic      [1:0]  command_kind,
  output logic      [2:0]  beam,
  output logic      [7:0]  value,
  output logic             last
);

  cfg_t              cfg;
  state_t            state;
  state_t            state_next;
  logic              running;
  logic [STEP_W-1:0] cur_step;
  logic [7:0]        tick;
  logic [BEAM_W-1:0] beam_cnt;
  logic [POS_W-1:0]  segment_start      [BEAM_COUNT];
  logic [POS_W-1:0]  commanded_position [BEAM_COUNT];
  logic              asc;
  logic [POS_W-1:0]  seg_q;

  logic              accept;
  op_t               op;
  logic              slot_free;
  logic              emit;
  logic [STEP_W-1:0] step_limit;
  logic [7:0]        divisor;
  logic              past_end;
  logic              beam_last;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [POS_W-1:0]  rd_position;
  logic [7:0]        rd_power;

  logic              div_start;
  logic [PROD_W-1:0] div_num;
  logic              div_busy;
  logic              div_done;
  logic [POS_W-1:0]  div_quo;

  logic [POS_W-1:0]  seg_b;
  logic [POS_W-1:0]  diff;
  logic [POS_W-1:0]  k1;
  logic [POS_W-1:0]  new_pos;

  kls_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kls_keyframe_ram u_ram (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_position (target_position),
    .wr_power    (target_power),
    .rd_addr     (rd_addr),
    .rd_position (rd_position),
    .rd_power    (rd_power)
  );

  kls_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .numerator (div_num),
    .divisor   (divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo)
  );

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign op         = op_t'(operation);
  assign slot_free  = !result_valid || !result_stall;

  assign step_limit = (int'(cfg.step_count) > MAX_STEPS) ? STEP_W'(MAX_STEPS)
                                                         : STEP_W'(cfg.step_count);
  assign divisor    = (cfg.inner_steps == 8'd0) ? 8'd1 : cfg.inner_steps;
  assign past_end   = cur_step >= step_limit;
  assign beam_last  = beam_cnt == BEAM_W'(BEAM_COUNT - 1);

  assign wr_en   = accept && (op == OP_WRITE) && (int'(beam_index) < BEAM_COUNT)
                   && (int'(step_index) < MAX_STEPS);
  assign wr_addr = table_addr({5'd0, beam_index}, {5'd0, step_index});
  assign rd_addr = table_addr(8'(beam_cnt), 8'(cur_step));

  always_comb begin
    seg_b     = segment_start[beam_cnt];
    k1        = tick + 8'd1;
    diff      = (rd_position >= seg_b) ? (rd_position - seg_b) : (seg_b - rd_position);
    div_num   = PROD_W'(diff) * PROD_W'(k1)
                + ((rd_position >= seg_b) ? PROD_W'(0) : PROD_W'(divisor - 8'd1));
    new_pos   = asc ? (seg_q + div_quo) : (seg_q - div_quo);
    div_start = (state == ST_POS_MUL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_START: begin
              if (!running) begin
                state_next = ST_OPEN;
              end
            end
            OP_TICK: begin
              if (running) begin
                if (past_end) begin
                  state_next = ST_FINISH;
                end else if (tick >= divisor) begin
                  state_next = ST_OPEN;
                end else begin
                  state_next = ST_POS_RD;
                end
              end
            end
            OP_STOP, OP_WRITE: ;
            default: ;
          endcase
        end
      end
      ST_OPEN: state_next = past_end ? ST_FINISH : ST_POW_RD;
      ST_FINISH: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_POW_RD: state_next = ST_POW_EMIT;
      ST_POW_EMIT: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = beam_last ? ST_IDLE : ST_POW_RD;
        end
      end
      ST_POS_RD:  state_next = ST_POS_MUL;
      ST_POS_MUL: state_next = ST_POS_DIV;
      ST_POS_DIV: begin
        if (div_done) begin
          state_next = ST_POS_EMIT;
        end
      end
      ST_POS_EMIT: begin
        if (slot_free) begin
          emit       = 1'b1;
          state_next = beam_last ? ST_IDLE : ST_POS_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      cur_step <= '0;
      tick     <= '0;
      beam_cnt <= '0;
      for (int b = 0; b < BEAM_COUNT; b++) begin
        segment_start[b]      <= '0;
        commanded_position[b] <= '0;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          beam_cnt <= '0;
          if (accept) begin
            unique case (op)
              OP_STOP: begin
                running  <= 1'b0;
                cur_step <= '0;
                tick     <= '0;
              end
              OP_START: begin
                if (!running) begin
                  running  <= 1'b1;
                  cur_step <= '0;
                end
              end
              OP_TICK: begin
                if (running && !past_end && tick >= divisor) begin
                  cur_step <= cur_step + 1'b1;
                end
              end
              OP_WRITE: ;
              default: ;
            endcase
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            running  <= 1'b0;
            cur_step <= '0;
            tick     <= '0;
          end
        end
        ST_POW_EMIT: begin
          if (slot_free) begin
            segment_start[beam_cnt] <= commanded_position[beam_cnt];
            if (beam_last) begin
              tick <= '0;
            end else begin
              beam_cnt <= beam_cnt + 1'b1;
            end
          end
        end
        ST_POS_EMIT: begin
          if (slot_free) begin
            commanded_position[beam_cnt] <= new_pos;
            if (beam_last) begin
              tick <= tick + 8'd1;
            end else begin
              beam_cnt <= beam_cnt + 1'b1;
            end
          end
        end
        ST_OPEN, ST_POW_RD, ST_POS_RD, ST_POS_MUL, ST_POS_DIV: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POS_MUL) begin
      asc   <= rd_position >= seg_b;
      seg_q <= seg_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      unique case (state)
        ST_FINISH: begin
          command_kind <= KIND_FINISHED;
          beam         <= '0;
          value        <= '0;
          last         <= 1'b1;
        end
        ST_POW_EMIT: begin
          command_kind <= KIND_POWER;
          beam         <= 3'(beam_cnt);
          value        <= rd_power;
          last         <= beam_last;
        end
        default: begin
          command_kind <= KIND_POSITION;
          beam         <= 3'(beam_cnt);
          value        <= new_pos;
          last         <= beam_last;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
      !running |-> (cur_step == '0) && (tick == '0))
    else $error("step or tick counter set while not running");
  a_finish_stops: assert property (@(posedge clk) disable iff (rst)
      (state == ST_FINISH) && slot_free |=> !running && result_valid && last)
    else $error("finished word did not stop the sequence");
  a_div_only_pos: assert property (@(posedge clk) disable iff (rst)
      div_busy |-> (state == ST_POS_DIV))
    else $error("divider busy outside the position pass");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the keyframe light sequencer
// Loads the keyframe table and drives tick, start, stop and table-write words
// under several step and tick settings, with random idling on both channels.
// A scoreboard predicts every power, position and finished word and checks
// the block's output against it in order, field by field.
// ----------------------------------------------------------------------------

module tb;
  import kls_pkg::*;

  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 3000;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] beam;
    logic [7:0] value;
    logic       last;
  } command_word_t;

  class light_scoreboard;
    logic [7:0]    position_tab [TABLE_SIZE];
    logic [7:0]    power_tab [TABLE_SIZE];
    logic [7:0]    seg_origin [BEAM_COUNT];
    logic [7:0]    last_commanded [BEAM_COUNT];
    bit            active;
    int unsigned   step_now;
    int unsigned   tick_now;
    int unsigned   cfg_steps;
    int unsigned   cfg_ticks;
    command_word_t awaited [$];
    int            faults;

    function new();
      foreach (position_tab[i]) begin
        position_tab[i] = 8'd0;
        power_tab[i] = 8'd0;
      end
      foreach (seg_origin[i]) begin
        seg_origin[i] = 8'd0;
        last_commanded[i] = 8'd0;
      end
      active = 1'b0;
      step_now = 0;
      tick_now = 0;
      cfg_steps = RESET_STEP_COUNT;
      cfg_ticks = RESET_INNER_STEPS;
      faults = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] data);
      if (idx == REG_STEP_COUNT) begin
        cfg_steps = data[3:0];
      end else begin
        cfg_ticks = data[7:0];
      end
    endfunction

    function int unsigned step_limit();
      return (cfg_steps > MAX_STEPS) ? MAX_STEPS : cfg_steps;
    endfunction

    function void emit(kind_t kind, int unsigned b, logic [7:0] v);
      command_word_t w;
      w.kind = kind;
      w.beam = 3'(b);
      w.value = v;
      w.last = 1'b0;
      awaited.push_back(w);
    endfunction

    function void go_idle();
      active = 1'b0;
      step_now = 0;
      tick_now = 0;
    endfunction

    function int open_step();
      if (step_now >= step_limit()) begin
        go_idle();
        emit(KIND_FINISHED, 0, 8'd0);
        return 1;
      end
      for (int b = 0; b < BEAM_COUNT; b++) begin
        emit(KIND_POWER, b, power_tab[b * MAX_STEPS + step_now]);
        seg_origin[b] = last_commanded[b];
      end
      tick_now = 0;
      return BEAM_COUNT;
    endfunction

    // Both directions round toward the lower position.
    function logic [7:0] ramp(int unsigned origin, int unsigned goal, int unsigned k1,
                              int unsigned div);
      if (goal >= origin) begin
        return 8'(origin + (goal - origin) * k1 / div);
      end
      return 8'(origin - ((origin - goal) * k1 + div - 1) / div);
    endfunction

    function void note_word(op_t op, logic [2:0] b, logic [2:0] s, logic [7:0] tpos,
                            logic [7:0] tpow);
      int unsigned div;
      int          n;
      logic [7:0]  p;
      div = (cfg_ticks == 0) ? 1 : cfg_ticks;
      n = 0;
      case (op)
        OP_WRITE: begin
          position_tab[b * MAX_STEPS + s] = tpos;
          power_tab[b * MAX_STEPS + s] = tpow;
        end
        OP_STOP: begin
          go_idle();
        end
        OP_START: begin
          if (!active) begin
            active = 1'b1;
            step_now = 0;
            n = open_step();
          end
        end
        default: begin
          if (active) begin
            if (step_now >= step_limit()) begin
              go_idle();
              emit(KIND_FINISHED, 0, 8'd0);
              n = 1;
            end else if (tick_now >= div) begin
              step_now++;
              n = open_step();
            end else begin
              for (int i = 0; i < BEAM_COUNT; i++) begin
                p = ramp(seg_origin[i], position_tab[i * MAX_STEPS + step_now],
                         tick_now + 1, div);
                last_commanded[i] = p;
                emit(KIND_POSITION, i, p);
              end
              n = BEAM_COUNT;
              tick_now = (tick_now + 1) & 8'hFF;
            end
          end
        end
      endcase
      if (n > 0) begin
        awaited[awaited.size() - 1].last = 1'b1;
      end
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= 10) begin
        $display("%s", msg);
      end
    endfunction

    function void check_word(logic [1:0] kind, logic [2:0] b, logic [7:0] v, logic l);
      command_word_t w;
      if (awaited.size() == 0) begin
        fault($sformatf("unexpected word: kind %0d beam %0d value %0d last %0d",
                        kind, b, v, l));
      end else begin
        w = awaited.pop_front();
        if (w.kind !== kind || w.beam !== b || w.value !== v || w.last !== l) begin
          fault($sformatf({"word mismatch: expected kind %0d beam %0d value %0d last %0d,",
                           " got kind %0d beam %0d value %0d last %0d"},
                          w.kind, w.beam, w.value, w.last, kind, b, v, l));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  operation = OP_TICK;
  logic [2:0]  beam_index = 3'd0;
  logic [2:0]  step_index = 3'd0;
  logic [7:0]  target_position = 8'd0;
  logic [7:0]  target_power = 8'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  command_kind;
  logic [2:0]  beam;
  logic [7:0]  value;
  logic        last;

  int send_idle = 14;
  int recv_idle = 58;
  int hold_left = 0;
  bit hold_req = 1'b0;
  int cycle_count = 0;
  light_scoreboard board;

  keyframe_light_sequencer u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      board.check_word(command_kind, beam, value, last);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_word(op_t op, logic [2:0] b, logic [2:0] s, logic [7:0] tpos,
                           logic [7:0] tpow);
    while ($urandom_range(0, 99) < send_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    operation <= op;
    beam_index <= b;
    step_index <= s;
    target_position <= tpos;
    target_power <= tpow;
    do @(posedge clk); while (item_stall);
    board.note_word(op, b, s, tpos, tpow);
  endtask

  task automatic drain_words();
    item_valid <= 1'b0;
    do @(posedge clk); while (board.awaited.size() != 0);
  endtask

  task automatic settle_block();
    drain_words();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_cfg(int steps, int ticks);
    write_reg(REG_STEP_COUNT, 32'(steps));
    write_reg(REG_INNER_STEPS, 32'(ticks));
  endtask

  task automatic random_words(int count);
    int          done;
    int unsigned r;
    op_t         op;
    bit          skipped;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if (!board.active) begin
        if (r < 75) begin
          op = OP_START;
        end else if (r < 85) begin
          op = OP_WRITE;
        end else if (r < 90) begin
          op = OP_STOP;
        end else begin
          op = OP_TICK;
        end
      end else if (r < 12) begin
        op = OP_WRITE;
      end else if (r < 15) begin
        op = OP_STOP;
      end else if (r < 19) begin
        op = OP_START;
      end else begin
        op = OP_TICK;
      end
      skipped = (op == OP_TICK && !board.active) || (op == OP_START && board.active);
      send_word(op, 3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
      if (!skipped) begin
        done++;
      end
    end
  endtask

  initial begin
    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Every entry is written before the first start, so no read finds an empty one.
    for (int b = 0; b < BEAM_COUNT; b++) begin
      for (int s = 0; s < MAX_STEPS; s++) begin
        if (b == 0 && s == 0) begin
          send_word(OP_WRITE, 3'd0, 3'd0, 8'd0, 8'd0);
        end else if (b == BEAM_COUNT - 1 && s == MAX_STEPS - 1) begin
          send_word(OP_WRITE, 3'd7, 3'd7, 8'd255, 8'd255);
        end else begin
          send_word(OP_WRITE, 3'(b), 3'(s), 8'($urandom), 8'($urandom));
        end
      end
    end
    settle_block();

    set_cfg(2, 2);
    send_word(OP_TICK, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_START, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_START, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_TICK, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_WRITE, 3'd7, 3'd0, 8'd255, 8'd255);
    send_word(OP_WRITE, 3'd0, 3'd0, 8'd0, 8'd0);
    repeat (5) send_word(OP_TICK, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_TICK, 3'd7, 3'd7, 8'd255, 8'd255);
    send_word(OP_TICK, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_START, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_TICK, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_STOP, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_TICK, 3'd0, 3'd0, 8'd0, 8'd0);
    settle_block();

    set_cfg(0, 40);
    send_word(OP_START, 3'd0, 3'd0, 8'd0, 8'd0);
    settle_block();

    set_cfg(15, 0);
    send_word(OP_START, 3'd0, 3'd0, 8'd0, 8'd0);
    repeat (3) send_word(OP_TICK, 3'd0, 3'd0, 8'd0, 8'd0);
    send_word(OP_STOP, 3'd7, 3'd7, 8'd255, 8'd255);
    settle_block();

    set_cfg(3, 4);
    random_words(20);
    settle_block();

    send_idle = 58;
    recv_idle = 14;
    set_cfg(8, 1);
    random_words(20);
    settle_block();

    send_idle = 0;
    recv_idle = 0;
    set_cfg(9, 3);
    hold_req = 1'b1;
    random_words(8);
    drain_words();
    random_words(6);
    settle_block();

    set_cfg(1, 255);
    random_words(8);
    settle_block();

    if (board.faults == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/kls_pkg.sv
src/kls_keyframe_ram.sv
src/kls_divider.sv
src/kls_apb_regs.sv
src/keyframe_light_sequencer.sv
bench/tb.sv
